FILE: design/ebc_pkg.sv
// Package for the expiry-sorted bounded cache.
// Holds the command and status codes, the record layout and the controller states.
// No dependencies.
package ebc_pkg;

	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_INSERT  = 2'd0;
	localparam cmd_t CMD_PEEK    = 2'd1;
	localparam cmd_t CMD_CONSUME = 2'd2;

	typedef logic [1:0] stat_t;
	localparam stat_t STAT_STORED   = 2'd0;
	localparam stat_t STAT_EVICTED  = 2'd1;
	localparam stat_t STAT_REJECTED = 2'd2;

	typedef struct packed {
		logic [63:0] node;
		logic [63:0] service;
		logic [63:0] expiry;
		logic [7:0]  index;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FULL_RD,
		S_FULL_CHK,
		S_SCAN_RD,
		S_WALK,
		S_PUT,
		S_HEAD_RD,
		S_HEAD_CAP
	} state_t;

endpackage

FILE: design/ebc_chan_if.sv
// Valid/ready channel interfaces for the command and response beats of the cache.
// Depends on ebc_pkg.
interface ebc_in_if;
	import ebc_pkg::*;

	logic        valid;
	logic        ready;
	cmd_t        command;
	logic [63:0] rec_node;
	logic [63:0] rec_service;
	logic [63:0] rec_expiry;
	logic [7:0]  rec_index;

	modport source (output valid, command, rec_node, rec_service, rec_expiry, rec_index,
		input ready);
	modport sink (input valid, command, rec_node, rec_service, rec_expiry, rec_index,
		output ready);
endinterface

interface ebc_out_if;
	import ebc_pkg::*;

	logic        valid;
	logic        ready;
	stat_t       status;
	logic        is_empty;
	logic [63:0] head_node;
	logic [63:0] head_service;
	logic [63:0] head_expiry;
	logic [7:0]  head_index;

	modport source (output valid, status, is_empty, head_node, head_service, head_expiry,
		head_index, input ready);
	modport sink (input valid, status, is_empty, head_node, head_service, head_expiry,
		head_index, output ready);
endinterface

FILE: design/ebc_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module ebc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: design/expiry_sorted_bounded_cache.sv
// Top level of the expiry-sorted bounded cache.
// Depends on ebc_pkg, ebc_chan_if and ebc_ram.
//
//   channel | direction | beat contents
//   cmd     | in        | command, rec_node, rec_service, rec_expiry, rec_index
//   rsp     | out       | status, is_empty, head_node, head_service, head_expiry, head_index
//
// Records sit in one RAM used as a ring; the front is a head pointer, so a consume
// takes the same path as a peek. An insert walks down from the back one record per
// cycle, moving each later record up one slot; into a full store it first checks the
// back record for eviction. Reset clears only the state, the count, the head pointer
// and the response valid flag. A response waits in an output register; the next
// command is taken meanwhile and holds in its last state until that response leaves.
module expiry_sorted_bounded_cache #(
	parameter int CACHE_DEPTH = 16
) (
	input logic clk,
	input logic arst_n,
	ebc_in_if.sink   cmd,
	ebc_out_if.source rsp
);
	import ebc_pkg::*;

	localparam int AW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
	localparam int CW = $clog2(CACHE_DEPTH + 1);
	localparam int SW = CW + 1;
	localparam logic [CW-1:0] FULL = CW'(CACHE_DEPTH);
	localparam logic [CW-1:0] LAST = CW'(CACHE_DEPTH - 1);
	localparam logic [AW-1:0] TOP_ADDR = AW'(CACHE_DEPTH - 1);

	state_t          state_q, state_d;
	logic [CW-1:0]   count_q;
	logic [AW-1:0]   head_q;
	logic [CW-1:0]   pos_q;
	rec_t            new_q;
	stat_t           stat_q;
	logic            out_valid_q;
	logic            out_empty_q;
	stat_t           out_stat_q;
	rec_t            out_rec_q;

	logic            accept;
	logic            cap;
	logic            older;
	logic            evict;
	logic [AW-1:0]   rd_addr;
	logic [AW-1:0]   wr_addr;
	logic            wr_en;
	rec_t            wr_data;
	logic [REC_W-1:0] rd_raw;
	rec_t            rd_data;

	function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
			input logic [CW-1:0] lpos);
		logic [SW-1:0] sum;
		sum = SW'(base) + SW'(lpos);
		if (sum >= SW'(CACHE_DEPTH)) begin
			sum = sum - SW'(CACHE_DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	assign rd_data = rec_t'(rd_raw);
	assign accept = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == S_IDLE);
	assign cap = (state_q == S_HEAD_CAP) && (!out_valid_q || rsp.ready);
	assign older = (rd_data.expiry >= new_q.expiry);
	assign evict = (rd_data.expiry > new_q.expiry);

	ebc_ram #(
		.WIDTH(REC_W),
		.DEPTH(CACHE_DEPTH)
	) u_slots (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.raddr(rd_addr),
		.rdata(rd_raw)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (cmd.command == CMD_INSERT) begin
						if (count_q == '0) begin
							state_d = S_PUT;
						end else if (count_q == FULL) begin
							state_d = S_FULL_RD;
						end else begin
							state_d = S_SCAN_RD;
						end
					end else begin
						state_d = S_HEAD_RD;
					end
				end
			end
			S_FULL_RD: state_d = S_FULL_CHK;
			S_FULL_CHK: begin
				if (!evict) begin
					state_d = S_HEAD_RD;
				end else if (pos_q == '0) begin
					state_d = S_PUT;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_SCAN_RD: state_d = S_WALK;
			S_WALK: begin
				if (!older) begin
					state_d = S_HEAD_RD;
				end else if (pos_q == '0) begin
					state_d = S_PUT;
				end
			end
			S_PUT: state_d = S_HEAD_RD;
			S_HEAD_RD: state_d = S_HEAD_CAP;
			S_HEAD_CAP: begin
				if (cap) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		rd_addr = phys(head_q, '0);
		wr_en = 1'b0;
		wr_addr = phys(head_q, pos_q + CW'(1));
		wr_data = new_q;
		unique case (state_q)
			S_FULL_RD, S_SCAN_RD: begin
				rd_addr = phys(head_q, pos_q);
			end
			S_WALK: begin
				if (pos_q != '0) begin
					rd_addr = phys(head_q, pos_q - CW'(1));
				end
				wr_en = 1'b1;
				if (older) begin
					wr_data = rd_data;
				end
			end
			S_PUT: begin
				wr_en = 1'b1;
				wr_addr = phys(head_q, '0);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			head_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					if (accept && cmd.command == CMD_CONSUME && count_q != '0) begin
						count_q <= count_q - CW'(1);
						head_q <= (head_q == TOP_ADDR) ? '0 : head_q + AW'(1);
					end
				end
				S_FULL_CHK: begin
					if (evict) begin
						count_q <= LAST;
					end
				end
				S_WALK: begin
					if (!older) begin
						count_q <= count_q + CW'(1);
					end
				end
				S_PUT: begin
					count_q <= count_q + CW'(1);
				end
				default: begin
				end
			endcase
			if (cap) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					new_q <= '{node: cmd.rec_node, service: cmd.rec_service,
						expiry: cmd.rec_expiry, index: cmd.rec_index};
					stat_q <= STAT_STORED;
					pos_q <= (count_q == FULL) ? LAST : count_q - CW'(1);
				end
			end
			S_FULL_CHK: begin
				stat_q <= evict ? STAT_EVICTED : STAT_REJECTED;
				pos_q <= pos_q - CW'(1);
			end
			S_WALK: begin
				pos_q <= pos_q - CW'(1);
			end
			default: begin
			end
		endcase
		if (cap) begin
			out_stat_q <= stat_q;
			out_empty_q <= (count_q == '0);
			out_rec_q <= (count_q == '0) ? '0 : rd_data;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.status = out_stat_q;
	assign rsp.is_empty = out_empty_q;
	assign rsp.head_node = out_rec_q.node;
	assign rsp.head_service = out_rec_q.service;
	assign rsp.head_expiry = out_rec_q.expiry;
	assign rsp.head_index = out_rec_q.index;

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= FULL)
		else $error("record count exceeds the cache depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (wr_addr != rd_addr))
		else $error("slot written and read in the same cycle");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FULL_CHK |-> count_q == FULL)
		else $error("eviction check entered with the store not full");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.command == CMD_CONSUME && count_q != '0
		|=> count_q == $past(count_q) - CW'(1))
		else $error("consume did not free the front slot");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE && !accept |=> $stable(count_q))
		else $error("record count changed while idle");

endmodule

FILE: sim/expiry_sorted_bounded_cache_checker.sv
// Checker for the expiry-sorted bounded cache: watches the command and response channels,
// keeps its own sorted copy of the store and compares every response beat with it.
// Depends on ebc_pkg and ebc_chan_if.
module expiry_sorted_bounded_cache_checker #(
	parameter int CACHE_DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	ebc_in_if    cmd,
	ebc_out_if   rsp,
	output int   fail_count,
	output int   pending
);
	import ebc_pkg::*;

	typedef struct packed {
		stat_t status;
		logic  is_empty;
		rec_t  head;
	} head_report_t;

	rec_t         cache_slot [CACHE_DEPTH];
	int           cache_fill;
	head_report_t expected_reports [$];

	function automatic stat_t insert_record(rec_t rec);
		stat_t outcome;
		int    pos;
		int    i;
		outcome = STAT_STORED;
		pos = 0;
		if (cache_fill >= CACHE_DEPTH) begin
			if (cache_slot[CACHE_DEPTH-1].expiry > rec.expiry) begin
				cache_fill = CACHE_DEPTH - 1;
				outcome = STAT_EVICTED;
			end else begin
				return STAT_REJECTED;
			end
		end
		while (pos < cache_fill && cache_slot[pos].expiry < rec.expiry)
			pos++;
		for (i = cache_fill; i > pos; i--)
			cache_slot[i] = cache_slot[i-1];
		cache_slot[pos] = rec;
		cache_fill++;
		return outcome;
	endfunction

	function automatic head_report_t apply_command(cmd_t op, rec_t rec);
		head_report_t report;
		int           i;
		report.status = STAT_STORED;
		case (op)
			CMD_INSERT: begin
				report.status = insert_record(rec);
			end
			CMD_CONSUME: begin
				if (cache_fill > 0) begin
					for (i = 0; i + 1 < cache_fill; i++)
						cache_slot[i] = cache_slot[i+1];
					cache_fill--;
				end
			end
			default: ;
		endcase
		report.is_empty = (cache_fill == 0);
		report.head = (cache_fill == 0) ? '0 : cache_slot[0];
		return report;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		head_report_t got;
		head_report_t want;
		rec_t         rec;
		if (!arst_n) begin
			cache_fill = 0;
			expected_reports.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// Responses are retired before a command of the same edge is predicted.
			if (rsp.valid && rsp.ready) begin
				got.status = rsp.status;
				got.is_empty = rsp.is_empty;
				got.head = '{rsp.head_node, rsp.head_service, rsp.head_expiry, rsp.head_index};
				if (expected_reports.size() == 0) begin
					if (fail_count < 10)
						$display("response beat with nothing expected: status=%0d empty=%0b",
							got.status, got.is_empty);
					fail_count++;
				end else begin
					want = expected_reports.pop_front();
					if (got !== want) begin
						if (fail_count < 10) begin
							$display("mismatch: expected status=%0d empty=%0b node=%h svc=%h exp=%h idx=%h",
								want.status, want.is_empty, want.head.node, want.head.service,
								want.head.expiry, want.head.index);
							$display("          actual   status=%0d empty=%0b node=%h svc=%h exp=%h idx=%h",
								got.status, got.is_empty, got.head.node, got.head.service,
								got.head.expiry, got.head.index);
						end
						fail_count++;
					end
				end
			end
			if (cmd.valid && cmd.ready) begin
				rec = '{cmd.rec_node, cmd.rec_service, cmd.rec_expiry, cmd.rec_index};
				expected_reports.push_back(apply_command(cmd.command, rec));
			end
			pending = expected_reports.size();
		end
	end

endmodule

FILE: sim/expiry_sorted_bounded_cache_tb.sv
// Testbench top for the expiry-sorted bounded cache: drives command beats and response stalls,
// and gives the verdict from the failure count of the checker.
// Depends on ebc_pkg, ebc_chan_if, expiry_sorted_bounded_cache and its checker.
module expiry_sorted_bounded_cache_tb;
	import ebc_pkg::*;

	localparam int   CACHE_DEPTH  = 16;
	localparam int   RANDOM_ITEMS = 500;
	localparam int   CYCLE_LIMIT  = 200000;
	localparam cmd_t CMD_UNUSED   = 2'd3;

	localparam int PHASE_FILL  = 0;
	localparam int PHASE_DRAIN = 1;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   cycle_count;
	bit   idle_on;

	ebc_in_if  cmd_ch ();
	ebc_out_if rsp_ch ();

	expiry_sorted_bounded_cache #(.CACHE_DEPTH(CACHE_DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	expiry_sorted_bounded_cache_checker #(.CACHE_DEPTH(CACHE_DEPTH)) cache_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_ch),
		.rsp        (rsp_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** expiry_sorted_bounded_cache: FAILED **");
		$finish;
	end

	initial begin
		int gap;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = idle_on ? $urandom_range(0, 11) : 0;
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
		end
	end

	function automatic logic [63:0] pick_word();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return '0;
		if (roll == 1)
			return '1;
		return {$urandom, $urandom};
	endfunction

	// Small expiries make ties and let a full store both evict and reject.
	function automatic logic [63:0] pick_expiry();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 5)
			return 64'($urandom_range(0, 31));
		if (roll < 7)
			return '1 - 64'($urandom_range(0, 31));
		return {$urandom, $urandom};
	endfunction

	task automatic send_beat(cmd_t op, logic [63:0] node, logic [63:0] service,
			logic [63:0] expiry, logic [7:0] index);
		int gap;
		gap = idle_on ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.command     <= op;
		cmd_ch.rec_node    <= node;
		cmd_ch.rec_service <= service;
		cmd_ch.rec_expiry  <= expiry;
		cmd_ch.rec_index   <= index;
		cmd_ch.valid       <= 1'b1;
		do @(posedge clk); while (!cmd_ch.ready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		cmd_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	initial begin
		int   issued;
		int   phase_kind;
		int   phase_len;
		int   roll;
		cmd_t op;
		arst_n = 1'b0;
		idle_on = 1'b1;
		cmd_ch.valid = 1'b0;
		cmd_ch.command = CMD_PEEK;
		cmd_ch.rec_node = '0;
		cmd_ch.rec_service = '0;
		cmd_ch.rec_expiry = '0;
		cmd_ch.rec_index = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_beat(CMD_PEEK, '0, '0, '0, '0);
		send_beat(CMD_CONSUME, '1, '1, '1, '1);
		send_beat(CMD_UNUSED, '0, '0, '0, '0);
		send_beat(CMD_INSERT, '1, '1, '1, 8'hFF);
		send_beat(CMD_INSERT, '0, '0, '0, 8'h00);
		send_beat(CMD_INSERT, 64'h5, 64'hA5A5_A5A5_A5A5_A5A5, '0, 8'h5A);
		send_beat(CMD_PEEK, '1, '1, '1, '1);
		send_beat(CMD_INSERT, 64'h3C3C_3C3C_3C3C_3C3C, 64'h7, '1, 8'hA5);
		send_beat(CMD_UNUSED, '1, '1, '1, '1);
		send_beat(CMD_CONSUME, '0, '0, '0, '0);
		send_beat(CMD_CONSUME, '0, '0, '0, '0);
		send_beat(CMD_CONSUME, '0, '0, '0, '0);
		send_beat(CMD_CONSUME, '0, '0, '0, '0);
		send_beat(CMD_CONSUME, '0, '0, '0, '0);
		wait_drained();

		issued = 0;
		while (issued < RANDOM_ITEMS) begin
			phase_kind = $urandom_range(0, 2);
			phase_len = $urandom_range(10, 60);
			idle_on <= ($urandom_range(0, 2) != 0);
			repeat (phase_len) begin
				roll = $urandom_range(0, 99);
				if (phase_kind == PHASE_FILL)
					op = roll < 80 ? CMD_INSERT : roll < 88 ? CMD_CONSUME :
						roll < 97 ? CMD_PEEK : CMD_UNUSED;
				else if (phase_kind == PHASE_DRAIN)
					op = roll < 20 ? CMD_INSERT : roll < 85 ? CMD_CONSUME :
						roll < 97 ? CMD_PEEK : CMD_UNUSED;
				else
					op = roll < 45 ? CMD_INSERT : roll < 75 ? CMD_CONSUME :
						roll < 95 ? CMD_PEEK : CMD_UNUSED;
				send_beat(op, pick_word(), pick_word(), pick_expiry(), 8'($urandom_range(0, 255)));
				issued++;
			end
			if ($urandom_range(0, 3) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (50) @(negedge clk);
		if (fail_count == 0)
			$display("** expiry_sorted_bounded_cache: PASSED **");
		else
			$display("** expiry_sorted_bounded_cache: FAILED **");
		$finish;
	end

endmodule

FILE: filelist.f
design/ebc_pkg.sv
design/ebc_chan_if.sv
design/ebc_ram.sv
design/expiry_sorted_bounded_cache.sv
sim/expiry_sorted_bounded_cache_checker.sv
sim/expiry_sorted_bounded_cache_tb.sv
